/* hdl/vbp_pkg.sv */
// Package of the Verlet ball physics step core: widths, codes, command and status types.
// Shared by the controller, the datapath, the arithmetic units and the top level.
package vbp_pkg;

    localparam int FRAC_BITS = 16;
    localparam int POS_W     = 24;
    localparam int CRD_W     = POS_W + 1;
    localparam int SUM_W     = POS_W + 3;
    localparam int ACC_W     = 2 * CRD_W;
    localparam int ROOT_W    = CRD_W;
    localparam int NUM_W     = 48;
    localparam int RAD_W     = 23;
    localparam int DT_W      = 16;
    localparam int G_W       = 17;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = IDX_W + 1;
    localparam int OIDX_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = RAD_W;
    localparam int G_SH      = 48 - FRAC_BITS;

    localparam logic [RAD_W-1:0]  HALF_Q = RAD_W'(1 << (FRAC_BITS - 1));
    localparam logic [ROOT_W-1:0] TWO_Q  = ROOT_W'(2 << FRAC_BITS);
    localparam logic [ACC_W-1:0]  TWO_SQ = ACC_W'(64'd1 << (2 * FRAC_BITS + 2));

    localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] SUM_MIN = -SUM_W'(8388608);

    localparam logic [1:0] ST_POS     = 2'd0;
    localparam logic [1:0] ST_SPAWNED = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;
    localparam logic [1:0] ST_EMPTY   = 2'd3;

    localparam logic OPC_STEP  = 1'b0;
    localparam logic OPC_SPAWN = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DT     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GRAV   = 2'd2;

    typedef logic [2:0][POS_W-1:0] t_vec;

    typedef enum logic [3:0] {
        OP_NONE, OP_GRAV1, OP_GRAV2, OP_CLR, OP_SQ_POS, OP_SQ_DIFF, OP_SQRT,
        OP_MUL_CLAMP, OP_MUL_COLL, OP_DIV, OP_UPD_CLAMP, OP_UPD_COLL, OP_OUT
    } t_op;

    typedef enum logic [2:0] {
        WR_NONE, WR_SPAWN, WR_INTEG, WR_A, WR_B
    } t_wr;

    typedef enum logic [4:0] {
        S_IDLE, S_GRAV1, S_GRAV2,
        S_C_RD, S_C_LD, S_C_SQ, S_C_CMP, S_C_SQW, S_C_MUL, S_C_DIV, S_C_DW, S_C_UPD,
        S_C_WR,
        S_I_RD, S_I_WR,
        S_P_RDA, S_P_RDB, S_P_LDB, S_P_SQ, S_P_CMP, S_P_SQW, S_P_MUL, S_P_DIV,
        S_P_DW, S_P_UPD, S_P_WRA, S_P_WRB,
        S_E_RD, S_E_OUT
    } t_state;

    typedef struct packed {
        t_op              op;
        t_wr              wr;
        logic             rd;
        logic             ld_a;
        logic             ld_b;
        logic [IDX_W-1:0] addr;
        logic [1:0]       coord;
        logic [1:0]       status;
        logic             last;
    } t_cmd;

    typedef struct packed {
        logic out_valid;
        logic sqrt_done;
        logic div_done;
        logic need_clamp;
        logic close;
    } t_stat;

    function automatic logic [POS_W-1:0] sat_pos(input logic signed [SUM_W-1:0] v);
        logic signed [SUM_W-1:0] t;
        t = v;
        if (v > SUM_MAX) t = SUM_MAX;
        if (v < SUM_MIN) t = SUM_MIN;
        return t[POS_W-1:0];
    endfunction

endpackage

/* hdl/verlet_ball_physics_step_core.sv */
// Verlet ball physics step core, top level: stream ports, controller and datapath.
// Depends on vbp_pkg, vbp_ctrl and vbp_dp.
//
// A spawn item is answered with one item in the cycle after it is taken.
// A step item with n balls runs the clamp, integrate and collide phases over the
// single-port position memories and then emits n items. Each clamped ball and each
// ordered pair that is pushed apart runs the square root unit once and the divider
// once for each of the three coordinates, and these set the cost of a clamp or a push.
// One item is worked on at a time; a new item is taken once the last result has
// left the output register. The position memories need no clearing after reset.
module verlet_ball_physics_step_core
    import vbp_pkg::*;
#(
    parameter int MAX_BALLS = 32
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [71:0]          s_axis_tdata,  // spawn_x, spawn_y, spawn_z
    input  logic                 s_axis_tuser,  // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [79:0]          m_axis_tdata,  // ball_index, out_x, out_y, out_z, zero fill
    output logic [1:0]           m_axis_tuser,  // status
    output logic                 m_axis_tlast,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd               cmd;
    t_stat              stat;
    t_vec               spawn;
    t_vec               out_pos;
    logic [OIDX_W-1:0]  out_idx;

    assign spawn = s_axis_tdata;

    vbp_ctrl #(.MAX_BALLS(MAX_BALLS)) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_opcode   (s_axis_tuser),
        .i_stat     (stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (cmd)
    );

    vbp_dp #(.MAX_BALLS(MAX_BALLS)) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (cmd),
        .i_spawn      (spawn),
        .i_out_ready  (m_axis_tready),
        .o_stat       (stat),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_idx    (out_idx),
        .o_out_pos    (out_pos),
        .o_out_last   (m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, out_pos, out_idx};

`ifndef ASSERT_OFF
    a_ready_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> !m_axis_tvalid)
        else $error("input taken while a result is pending");
    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (cmd.op == OP_OUT) |-> !stat.out_valid)
        else $error("output register overwritten");
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");
`endif

endmodule

/* hdl/vbp_sqrt.sv */
// Floor integer square root, one result bit per cycle.
// Depends on vbp_pkg for widths.
module vbp_sqrt
    import vbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [ACC_W-1:0]  i_rad,
    output logic              o_done,
    output logic [ROOT_W-1:0] o_root
);

    localparam int REM_W = ROOT_W + 2;

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [4:0]         r_cnt, n_cnt;
    logic [ACC_W-1:0]   r_rad, n_rad;
    logic [REM_W-1:0]   r_rem, n_rem;
    logic [ROOT_W-1:0]  r_root, n_root;
    logic [REM_W+1:0]   trial_rem;
    logic [REM_W+1:0]   trial;

    always_comb begin
        trial_rem = {r_rem, r_rad[ACC_W-1 -: 2]};
        trial     = (REM_W + 2)'({r_root, 2'b01});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 5'(ROOT_W);
            n_rad  = i_rad;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad = {r_rad[ACC_W-3:0], 2'b00};
            if (trial_rem >= trial) begin
                n_rem  = REM_W'(trial_rem - trial);
                n_root = {r_root[ROOT_W-2:0], 1'b1};
            end else begin
                n_rem  = REM_W'(trial_rem);
                n_root = {r_root[ROOT_W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

/* hdl/vbp_div.sv */
// Unsigned restoring divider, one quotient bit per cycle.
// Depends on vbp_pkg for widths.
module vbp_div
    import vbp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [ROOT_W-1:0] i_den,
    output logic              o_done,
    output logic [NUM_W-1:0]  o_quot
);

    logic               r_busy, n_busy;
    logic               r_done, n_done;
    logic [5:0]         r_cnt, n_cnt;
    logic [NUM_W-1:0]   r_work, n_work;
    logic [ROOT_W-1:0]  r_rem, n_rem;
    logic [ROOT_W-1:0]  r_den, n_den;
    logic [ROOT_W:0]    t;
    logic               ge;

    always_comb begin
        t  = {r_rem, r_work[NUM_W-1]};
        ge = (t >= {1'b0, r_den});
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'(NUM_W);
            n_work = i_num;
            n_rem  = '0;
            n_den  = i_den;
        end else if (r_busy) begin
            n_work = {r_work[NUM_W-2:0], ge};
            n_rem  = ge ? ROOT_W'(t - {1'b0, r_den}) : ROOT_W'(t);
            n_cnt  = r_cnt - 6'd1;
            if (r_cnt == 6'd1) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_den  <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = r_work;

endmodule

/* hdl/vbp_dp.sv */
// Datapath: position memories, configuration registers, arithmetic and output register.
// Depends on vbp_pkg, vbp_sqrt and vbp_div; driven by commands from vbp_ctrl.
module vbp_dp
    import vbp_pkg::*;
#(
    parameter int MAX_BALLS = 32
)
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  t_cmd                 i_cmd,
    input  t_vec                 i_spawn,
    input  logic                 i_out_ready,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [1:0]           o_out_status,
    output logic [OIDX_W-1:0]    o_out_idx,
    output t_vec                 o_out_pos,
    output logic                 o_out_last
);

    localparam int AW = (MAX_BALLS > 1) ? $clog2(MAX_BALLS) : 1;

    t_vec mem_cur  [MAX_BALLS];
    t_vec mem_prev [MAX_BALLS];

    logic [AW-1:0]            addr;
    logic [RAD_W-1:0]         r_radius;
    logic [DT_W-1:0]          r_dt;
    logic [DT_W-1:0]          r_grav;
    logic                     r_out_valid;
    logic [1:0]               r_out_status;
    logic [OIDX_W-1:0]        r_out_idx;
    t_vec                     r_out_pos;
    logic                     r_out_last;
    t_vec                     r_rd_cur, r_rd_prev;
    t_vec                     r_a, r_b;
    logic [2:0][CRD_W-1:0]    r_diff;
    logic [ACC_W-1:0]         r_acc;
    logic [RAD_W-1:0]         r_lim;
    logic [2*RAD_W-1:0]       r_lim2;
    logic [2*DT_W-1:0]        r_g1;
    logic [G_W-1:0]           r_g;
    logic [NUM_W-1:0]         r_num;
    logic [ROOT_W-1:0]        r_den;

    logic                     sqrt_done, div_done;
    logic [ROOT_W-1:0]        root;
    logic [NUM_W-1:0]         quot;

    logic signed [POS_W-1:0]  a_c, b_c;
    logic [POS_W-1:0]         a_abs;
    logic signed [CRD_W-1:0]  d_c, dr_c;
    logic [CRD_W-1:0]         d_abs, dr_abs;
    logic [2*POS_W-1:0]       sq_pos;
    logic [ACC_W-1:0]         sq_diff;
    logic [NUM_W-1:0]         prod_cl, prod_co;
    logic [ROOT_W-1:0]        delta;
    logic [NUM_W-1:0]         g_prod;
    logic signed [SUM_W-1:0]  q_mag, s_cl, s_co;
    t_vec                     integ;
    logic signed [SUM_W-1:0]  cw [3];
    logic signed [SUM_W-1:0]  pw [3];
    logic signed [SUM_W-1:0]  gw [3];

    assign addr = i_cmd.addr[AW-1:0];

    vbp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_SQRT),
        .i_rad   (r_acc),
        .o_done  (sqrt_done),
        .o_root  (root)
    );

    vbp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.op == OP_DIV),
        .i_num   (r_num),
        .i_den   (r_den),
        .o_done  (div_done),
        .o_quot  (quot)
    );

    always_comb begin
        a_c     = $signed(r_a[i_cmd.coord]);
        b_c     = $signed(r_b[i_cmd.coord]);
        a_abs   = a_c[POS_W-1] ? POS_W'(-a_c) : POS_W'(a_c);
        d_c     = CRD_W'(a_c) - CRD_W'(b_c);
        d_abs   = d_c[CRD_W-1] ? CRD_W'(-d_c) : CRD_W'(d_c);
        dr_c    = $signed(r_diff[i_cmd.coord]);
        dr_abs  = dr_c[CRD_W-1] ? CRD_W'(-dr_c) : CRD_W'(dr_c);
        sq_pos  = a_abs * a_abs;
        sq_diff = d_abs * d_abs;
        prod_cl = NUM_W'(a_abs) * NUM_W'(r_lim);
        delta   = TWO_Q - root;
        prod_co = NUM_W'(dr_abs) * NUM_W'(delta);
        g_prod  = NUM_W'(r_g1) * NUM_W'(r_grav);
        q_mag   = $signed({2'b00, quot[ROOT_W-1:0]});
        s_cl    = a_c[POS_W-1] ? -q_mag : q_mag;
        s_co    = dr_c[CRD_W-1] ? -q_mag : q_mag;
        for (int k = 0; k < 3; k++) begin
            cw[k]    = SUM_W'($signed(r_rd_cur[k]));
            pw[k]    = SUM_W'($signed(r_rd_prev[k]));
            gw[k]    = (k == 1) ? $signed({{(SUM_W-G_W){1'b0}}, r_g}) : '0;
            integ[k] = sat_pos((cw[k] <<< 1) - pw[k] - gw[k]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius    <= RAD_W'(458752);
            r_dt        <= DT_W'(6554);
            r_grav      <= DT_W'(655);
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_RADIUS: r_radius <= i_cfg_data;
                    CFG_DT:     r_dt     <= i_cfg_data[DT_W-1:0];
                    CFG_GRAV:   r_grav   <= i_cfg_data[DT_W-1:0];
                    default:    ;
                endcase
            end
            if (i_cmd.op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_cur  <= mem_cur[addr];
            r_rd_prev <= mem_prev[addr];
        end
        case (i_cmd.wr)
            WR_SPAWN: begin
                mem_cur[addr]  <= i_spawn;
                mem_prev[addr] <= i_spawn;
            end
            WR_INTEG: begin
                mem_cur[addr]  <= integ;
                mem_prev[addr] <= r_rd_cur;
            end
            WR_A:    mem_cur[addr] <= r_a;
            WR_B:    mem_cur[addr] <= r_b;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.ld_a) r_a <= r_rd_cur;
        if (i_cmd.ld_b) r_b <= r_rd_cur;
        case (i_cmd.op)
            OP_GRAV1: begin
                r_g1  <= r_dt * r_dt;
                r_lim <= (r_radius >= HALF_Q) ? r_radius - HALF_Q : '0;
            end
            OP_GRAV2: begin
                r_g    <= G_W'((g_prod + (NUM_W'(1) << (G_SH - 1))) >> G_SH);
                r_lim2 <= r_lim * r_lim;
            end
            OP_CLR:     r_acc <= '0;
            OP_SQ_POS:  r_acc <= r_acc + ACC_W'(sq_pos);
            OP_SQ_DIFF: begin
                r_acc                 <= r_acc + sq_diff;
                r_diff[i_cmd.coord]   <= d_c;
            end
            OP_MUL_CLAMP: begin
                r_num <= prod_cl + NUM_W'(root >> 1);
                r_den <= root;
            end
            OP_MUL_COLL: begin
                r_num <= prod_co + NUM_W'(root);
                r_den <= {root[ROOT_W-2:0], 1'b0};
            end
            OP_UPD_CLAMP: r_a[i_cmd.coord] <= sat_pos(s_cl);
            OP_UPD_COLL: begin
                r_a[i_cmd.coord] <= sat_pos(SUM_W'(a_c) + s_co);
                r_b[i_cmd.coord] <= sat_pos(SUM_W'(b_c) - s_co);
            end
            OP_OUT: begin
                r_out_status <= i_cmd.status;
                r_out_idx    <= i_cmd.addr[OIDX_W-1:0];
                r_out_last   <= i_cmd.last;
                case (i_cmd.status)
                    ST_POS:     r_out_pos <= r_rd_cur;
                    ST_SPAWNED: r_out_pos <= i_spawn;
                    default:    r_out_pos <= '0;
                endcase
            end
            default: ;
        endcase
    end

    always_comb begin
        o_stat.out_valid  = r_out_valid;
        o_stat.sqrt_done  = sqrt_done;
        o_stat.div_done   = div_done;
        o_stat.need_clamp = (r_acc > ACC_W'(r_lim2));
        o_stat.close      = (r_acc != '0) && (r_acc < TWO_SQ);
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_idx    = r_out_idx;
    assign o_out_pos    = r_out_pos;
    assign o_out_last   = r_out_last;

endmodule

/* hdl/vbp_ctrl.sv */
// Controller: ball count, loop counters and the phase sequencer.
// Depends on vbp_pkg; issues commands to vbp_dp and reads its status.
module vbp_ctrl
    import vbp_pkg::*;
#(
    parameter int MAX_BALLS = 32
)
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    input  logic  i_opcode,
    input  t_stat i_stat,
    output logic  o_in_ready,
    output t_cmd  o_cmd
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [1:0]         r_c, n_c;
    logic               accept, full, i_last, j_last, c_last;

    assign o_in_ready = (r_state == S_IDLE) && !i_stat.out_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign full       = (r_cnt == CNT_W'(MAX_BALLS));
    assign i_last     = (CNT_W'(r_i) == r_cnt - CNT_W'(1));
    assign j_last     = (CNT_W'(r_j) == r_cnt - CNT_W'(1));
    assign c_last     = (r_c == 2'd2);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_i     = r_i;
        n_j     = r_j;
        n_c     = r_c;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_opcode == OPC_SPAWN) begin
                        if (!full) n_cnt = r_cnt + CNT_W'(1);
                    end else if (r_cnt != '0) begin
                        n_state = S_GRAV1;
                        n_i     = '0;
                    end
                end
            end
            S_GRAV1: n_state = S_GRAV2;
            S_GRAV2: n_state = S_C_RD;
            S_C_RD:  n_state = S_C_LD;
            S_C_LD: begin
                n_state = S_C_SQ;
                n_c     = '0;
            end
            S_C_SQ: begin
                n_c = r_c + 2'd1;
                if (c_last) n_state = S_C_CMP;
            end
            S_C_CMP: begin
                n_c = '0;
                if (i_stat.need_clamp) begin
                    n_state = S_C_SQW;
                end else if (i_last) begin
                    n_state = S_I_RD;
                    n_i     = '0;
                end else begin
                    n_state = S_C_RD;
                    n_i     = r_i + IDX_W'(1);
                end
            end
            S_C_SQW: if (i_stat.sqrt_done) n_state = S_C_MUL;
            S_C_MUL: n_state = S_C_DIV;
            S_C_DIV: n_state = S_C_DW;
            S_C_DW:  if (i_stat.div_done) n_state = S_C_UPD;
            S_C_UPD: begin
                n_c     = r_c + 2'd1;
                n_state = c_last ? S_C_WR : S_C_MUL;
            end
            S_C_WR: begin
                if (i_last) begin
                    n_state = S_I_RD;
                    n_i     = '0;
                end else begin
                    n_state = S_C_RD;
                    n_i     = r_i + IDX_W'(1);
                end
            end
            S_I_RD: n_state = S_I_WR;
            S_I_WR: begin
                if (i_last) begin
                    n_state = S_P_RDA;
                    n_i     = '0;
                    n_j     = '0;
                end else begin
                    n_state = S_I_RD;
                    n_i     = r_i + IDX_W'(1);
                end
            end
            S_P_RDA: n_state = S_P_RDB;
            S_P_RDB: n_state = S_P_LDB;
            S_P_LDB: begin
                n_state = S_P_SQ;
                n_c     = '0;
            end
            S_P_SQ: begin
                n_c = r_c + 2'd1;
                if (c_last) n_state = S_P_CMP;
            end
            S_P_CMP: begin
                n_c = '0;
                if (i_stat.close) begin
                    n_state = S_P_SQW;
                end else if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_state = S_E_RD;
                        n_i     = '0;
                    end else begin
                        n_state = S_P_RDA;
                        n_i     = r_i + IDX_W'(1);
                    end
                end else begin
                    n_state = S_P_RDA;
                    n_j     = r_j + IDX_W'(1);
                end
            end
            S_P_SQW: if (i_stat.sqrt_done) n_state = S_P_MUL;
            S_P_MUL: n_state = S_P_DIV;
            S_P_DIV: n_state = S_P_DW;
            S_P_DW:  if (i_stat.div_done) n_state = S_P_UPD;
            S_P_UPD: begin
                n_c     = r_c + 2'd1;
                n_state = c_last ? S_P_WRA : S_P_MUL;
            end
            S_P_WRA: n_state = S_P_WRB;
            S_P_WRB: begin
                if (j_last) begin
                    n_j = '0;
                    if (i_last) begin
                        n_state = S_E_RD;
                        n_i     = '0;
                    end else begin
                        n_state = S_P_RDA;
                        n_i     = r_i + IDX_W'(1);
                    end
                end else begin
                    n_state = S_P_RDA;
                    n_j     = r_j + IDX_W'(1);
                end
            end
            S_E_RD: n_state = S_E_OUT;
            S_E_OUT: begin
                if (!i_stat.out_valid) begin
                    if (i_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_E_RD;
                        n_i     = r_i + IDX_W'(1);
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.wr     = WR_NONE;
        o_cmd.addr   = r_i;
        o_cmd.coord  = r_c;
        o_cmd.status = ST_POS;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.op   = OP_OUT;
                    o_cmd.last = 1'b1;
                    o_cmd.addr = '0;
                    if (i_opcode == OPC_SPAWN) begin
                        if (full) begin
                            o_cmd.status = ST_FULL;
                        end else begin
                            o_cmd.status = ST_SPAWNED;
                            o_cmd.wr     = WR_SPAWN;
                            o_cmd.addr   = r_cnt[IDX_W-1:0];
                        end
                    end else if (r_cnt == '0) begin
                        o_cmd.status = ST_EMPTY;
                    end else begin
                        o_cmd.op = OP_NONE;
                    end
                end
            end
            S_GRAV1: o_cmd.op = OP_GRAV1;
            S_GRAV2: o_cmd.op = OP_GRAV2;
            S_C_RD: begin
                o_cmd.rd = 1'b1;
                o_cmd.op = OP_CLR;
            end
            S_C_LD:  o_cmd.ld_a = 1'b1;
            S_C_SQ:  o_cmd.op = OP_SQ_POS;
            S_C_CMP: if (i_stat.need_clamp) o_cmd.op = OP_SQRT;
            S_C_MUL: o_cmd.op = OP_MUL_CLAMP;
            S_C_DIV: o_cmd.op = OP_DIV;
            S_C_UPD: o_cmd.op = OP_UPD_CLAMP;
            S_C_WR:  o_cmd.wr = WR_A;
            S_I_RD:  o_cmd.rd = 1'b1;
            S_I_WR:  o_cmd.wr = WR_INTEG;
            S_P_RDA: begin
                o_cmd.rd = 1'b1;
                o_cmd.op = OP_CLR;
            end
            S_P_RDB: begin
                o_cmd.ld_a = 1'b1;
                o_cmd.rd   = 1'b1;
                o_cmd.addr = r_j;
            end
            S_P_LDB: o_cmd.ld_b = 1'b1;
            S_P_SQ:  o_cmd.op = OP_SQ_DIFF;
            S_P_CMP: if (i_stat.close) o_cmd.op = OP_SQRT;
            S_P_MUL: o_cmd.op = OP_MUL_COLL;
            S_P_DIV: o_cmd.op = OP_DIV;
            S_P_UPD: o_cmd.op = OP_UPD_COLL;
            S_P_WRA: o_cmd.wr = WR_A;
            S_P_WRB: begin
                o_cmd.wr   = WR_B;
                o_cmd.addr = r_j;
            end
            S_E_RD:  o_cmd.rd = 1'b1;
            S_E_OUT: begin
                if (!i_stat.out_valid) begin
                    o_cmd.op   = OP_OUT;
                    o_cmd.last = i_last;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_c     <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_i     <= n_i;
            r_j     <= n_j;
            r_c     <= n_c;
        end
    end

endmodule

/* dv/verlet_ball_physics_step_core_test.sv */
// Testbench of verlet_ball_physics_step_core: directed table, then random spawn and step items,
// each result checked against a built-in ball table model. Depends on vbp_pkg and the core.
`timescale 1ns / 1ps

module verlet_ball_physics_step_core_test;
    import vbp_pkg::*;

    localparam int NBALLS    = 32;
    localparam int WD_LIMIT  = 600000;
    localparam int MAX_SHOWN = 10;

    typedef struct packed {
        logic [1:0]       st;
        logic [4:0]       bi;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [POS_W-1:0] z;
        logic             lst;
    } t_ball_res;

    typedef enum logic {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind  kind;
        logic       op;
        logic [23:0] x, y, z;
        logic       typed;
        t_ball_res  res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [71:0] s_axis_tdata = '0;  // spawn_x, spawn_y, spawn_z
    logic        s_axis_tuser = OPC_STEP;  // opcode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [79:0] m_axis_tdata;  // ball_index, out_x, out_y, out_z, zero fill
    logic [1:0]  m_axis_tuser;  // status
    logic        m_axis_tlast;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = CFG_RADIUS;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    verlet_ball_physics_step_core #(.MAX_BALLS(NBALLS)) i_dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ball table model
    longint      cur_pos [NBALLS][3];
    longint      old_pos [NBALLS][3];
    int          nballs;
    longint      radius_q, dt_q, grav_q;
    t_ball_res   pos_queue[$];

    int n_err, n_res, n_steps, n_spawns, n_full, n_cfg;
    bit quiet_mode;
    int idle_cnt;

    function automatic longint sat_coord(longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint div_half_away(longint num, longint unsigned den);
        longint unsigned mag, q;
        mag = (num < 0) ? -num : num;
        q = (mag + den / 2) / den;
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic t_ball_res mk_res(logic [1:0] st, int bi, longint x, longint y,
                                         longint z, logic lst);
        t_ball_res r;
        r.st = st;
        r.bi = bi[4:0];
        r.x = x[23:0];
        r.y = y[23:0];
        r.z = z[23:0];
        r.lst = lst;
        return r;
    endfunction

    task automatic advance_balls();
        longint lim, g, d2, d, nv, s;
        longint diff[3];
        lim = radius_q - (1 << (FRAC_BITS - 1));
        if (lim < 0) lim = 0;
        for (int i = 0; i < nballs; i++) begin
            d2 = 0;
            for (int c = 0; c < 3; c++) d2 += cur_pos[i][c] * cur_pos[i][c];
            if (d2 > lim * lim) begin
                d = root_floor(d2);
                for (int c = 0; c < 3; c++)
                    cur_pos[i][c] = sat_coord(div_half_away(cur_pos[i][c] * lim, d));
            end
        end
        g = (dt_q * dt_q * grav_q + (64'd1 << (G_SH - 1))) >> G_SH;
        for (int i = 0; i < nballs; i++)
            for (int c = 0; c < 3; c++) begin
                nv = 2 * cur_pos[i][c] - old_pos[i][c];
                if (c == 1) nv -= g;
                old_pos[i][c] = cur_pos[i][c];
                cur_pos[i][c] = sat_coord(nv);
            end
        for (int i = 0; i < nballs; i++)
            for (int j = 0; j < nballs; j++) begin
                d2 = 0;
                for (int c = 0; c < 3; c++) begin
                    diff[c] = cur_pos[i][c] - cur_pos[j][c];
                    d2 += diff[c] * diff[c];
                end
                if (d2 != 0 && d2 < (64'd1 << (2 * FRAC_BITS + 2))) begin
                    d = root_floor(d2);
                    for (int c = 0; c < 3; c++) begin
                        s = div_half_away(diff[c] * ((2 << FRAC_BITS) - d), 2 * d);
                        cur_pos[i][c] = sat_coord(cur_pos[i][c] + s);
                        cur_pos[j][c] = sat_coord(cur_pos[j][c] - s);
                    end
                end
            end
    endtask

    task automatic predict_item(logic op, logic [23:0] x, logic [23:0] y, logic [23:0] z);
        if (op == OPC_SPAWN) begin
            if (nballs >= NBALLS) begin
                pos_queue.push_back(mk_res(ST_FULL, 0, 0, 0, 0, 1'b1));
                n_full++;
            end else begin
                cur_pos[nballs][0] = longint'(signed'(x));
                cur_pos[nballs][1] = longint'(signed'(y));
                cur_pos[nballs][2] = longint'(signed'(z));
                for (int c = 0; c < 3; c++) old_pos[nballs][c] = cur_pos[nballs][c];
                pos_queue.push_back(mk_res(ST_SPAWNED, nballs, cur_pos[nballs][0],
                                           cur_pos[nballs][1], cur_pos[nballs][2], 1'b1));
                nballs++;
                n_spawns++;
            end
        end else if (nballs == 0) begin
            pos_queue.push_back(mk_res(ST_EMPTY, 0, 0, 0, 0, 1'b1));
        end else begin
            advance_balls();
            for (int i = 0; i < nballs; i++)
                pos_queue.push_back(mk_res(ST_POS, i, cur_pos[i][0], cur_pos[i][1],
                                           cur_pos[i][2], i == nballs - 1));
            n_steps++;
        end
    endtask

    function automatic int draw_gap();
        return quiet_mode ? 0 : $urandom_range(0, 15);
    endfunction

    // sender: called at a rising edge; valid stays high across back-to-back items
    task automatic send_item(logic op, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                             bit typed, t_ball_res res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {z, y, x};
        @(posedge i_clk);
        while (!(s_axis_tvalid && s_axis_tready)) @(posedge i_clk);
        predict_item(op, x, y, z);
        if (typed) begin
            void'(pos_queue.pop_back());
            pos_queue.push_back(res);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pos_queue.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_regs(logic [22:0] rad, logic [15:0] dt, logic [15:0] g);
        logic [CFG_W-1:0] vals[4];
        vals = '{rad, CFG_W'(dt), CFG_W'(g), CFG_W'($urandom)};
        for (int k = 0; k < 4; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_idx <= CFG_IDX_W'(k);
            i_cfg_data <= vals[k];
            @(posedge i_clk);
        end
        i_cfg_we <= 1'b0;
        radius_q = rad;
        dt_q = dt;
        grav_q = g;
        n_cfg++;
    endtask

    // receiver with random stalls
    int stall_left;
    always @(posedge i_clk) begin
        int gap;
        gap = draw_gap();
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (gap == 0) begin
                stall_left <= 0;
            end else begin
                m_axis_tready <= 1'b0;
                stall_left <= gap;
            end
        end else if (stall_left > 1) begin
            stall_left <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left <= 0;
        end
    end

    always @(posedge i_clk) begin
        t_ball_res got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = mk_res(m_axis_tuser, m_axis_tdata[4:0], m_axis_tdata[28:5],
                         m_axis_tdata[52:29], m_axis_tdata[76:53], m_axis_tlast);
            n_res++;
            if (pos_queue.size() == 0) begin
                n_err++;
                if (n_err <= MAX_SHOWN) $display("unexpected item %p", got);
            end else begin
                want = pos_queue.pop_front();
                if (got !== want) begin
                    n_err++;
                    if (n_err <= MAX_SHOWN)
                        $display("mismatch st %0d/%0d idx %0d/%0d x %h/%h y %h/%h z %h/%h last %b/%b",
                                 want.st, got.st, want.bi, got.bi, want.x, got.x,
                                 want.y, got.y, want.z, got.z, want.lst, got.lst);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WD_LIMIT) begin
            $display("FAIL verlet_ball_physics_step_core");
            $finish;
        end
    end

    t_row rows[$];

    function automatic t_row item_row(logic op, logic [23:0] x, logic [23:0] y,
                                      logic [23:0] z, bit typed, t_ball_res res);
        t_row r;
        r.kind = ROW_ITEM;
        r.op = op;
        r.x = x;
        r.y = y;
        r.z = z;
        r.typed = typed;
        r.res = res;
        return r;
    endfunction

    function automatic t_row cfg_row(logic [23:0] rad, logic [23:0] dt, logic [23:0] g);
        t_row r;
        r = item_row(OPC_STEP, rad, dt, g, 1'b0, '0);
        r.kind = ROW_CFG;
        return r;
    endfunction

    initial begin
        t_ball_res none;
        logic [23:0] sx, sy, sz;
        none = '0;
        nballs = 0;
        radius_q = 458752;
        dt_q = 6554;
        grav_q = 655;
        for (int i = 0; i < NBALLS; i++)
            for (int c = 0; c < 3; c++) begin
                cur_pos[i][c] = 0;
                old_pos[i][c] = 0;
            end

        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 1, mk_res(ST_EMPTY, 0, 0, 0, 0, 1)));
        rows.push_back(item_row(OPC_SPAWN, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1,
                                mk_res(ST_SPAWNED, 0, 8388607, 8388607, 8388607, 1)));
        rows.push_back(item_row(OPC_SPAWN, 24'h800000, 24'h800000, 24'h800000, 1,
                                mk_res(ST_SPAWNED, 1, -8388608, -8388608, -8388608, 1)));
        rows.push_back(item_row(OPC_SPAWN, 0, 0, 0, 1, mk_res(ST_SPAWNED, 2, 0, 0, 0, 1)));
        rows.push_back(item_row(OPC_SPAWN, 24'h010000, 0, 0, 1,
                                mk_res(ST_SPAWNED, 3, 65536, 0, 0, 1)));
        rows.push_back(item_row(OPC_SPAWN, 24'h010000, 0, 0, 1,
                                mk_res(ST_SPAWNED, 4, 65536, 0, 0, 1)));
        rows.push_back(item_row(OPC_SPAWN, 24'hFF8000, 24'h018000, 24'h00C000, 0, none));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));
        rows.push_back(item_row(OPC_STEP, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 0, none));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));
        rows.push_back(cfg_row(0, 6554, 655));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));
        rows.push_back(cfg_row(24'h7FFFFF, 65535, 65535));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));
        rows.push_back(cfg_row(458752, 0, 0));
        rows.push_back(item_row(OPC_STEP, 0, 0, 0, 0, none));

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[k]) begin
            if (rows[k].kind == ROW_CFG) begin
                wait_idle();
                write_regs(rows[k].x[22:0], rows[k].y[15:0], rows[k].z[15:0]);
            end else begin
                send_item(rows[k].op, rows[k].x, rows[k].y, rows[k].z,
                          rows[k].typed, rows[k].res);
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            wait_idle();
            quiet_mode = (ph == 1);
            case ($urandom_range(0, 3))
                0: sx = 0;
                1: sx = 24'h7FFFFF;
                default: sx = 24'($urandom_range(200000, 800000));
            endcase
            write_regs(sx[22:0], ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom),
                       ($urandom_range(0, 3) == 0) ? 16'h0000 : 16'($urandom));
            for (int k = 0; k < 25; k++) begin
                if ($urandom_range(0, 9) < 3) begin
                    send_item(OPC_STEP, 24'($urandom), 24'($urandom), 24'($urandom),
                              0, none);
                end else if ($urandom_range(0, 9) < 7) begin
                    sx = 24'($urandom_range(0, 524288) - 262144);
                    sy = 24'($urandom_range(0, 524288) - 262144);
                    sz = 24'($urandom_range(0, 524288) - 262144);
                    send_item(OPC_SPAWN, sx, sy, sz, 0, none);
                end else begin
                    send_item(OPC_SPAWN, 24'($urandom), 24'($urandom), 24'($urandom),
                              0, none);
                end
            end
        end

        wait_idle();
        repeat (50) @(posedge i_clk);
        $display("covered %0d steps, %0d spawns, %0d full-table spawns, %0d register sets",
                 n_steps, n_spawns, n_full, n_cfg);
        $display("%0d results checked, %0d mismatches, %0d still expected",
                 n_res, n_err, pos_queue.size());
        if (n_err == 0 && pos_queue.size() == 0)
            $display("PASS verlet_ball_physics_step_core");
        else
            $display("FAIL verlet_ball_physics_step_core");
        $finish;
    end

endmodule
